// ===== rtl/core/simu_pkg.sv =====
package simu_pkg;

  // Default geometry of the register file and its fixed locations.
  localparam int REG_COUNT_DEF      = 128;
  localparam int TIMESTAMP_ADDR_DEF = 18;
  localparam int YAW_ADDR_DEF       = 22;
  localparam int IDENT_ADDR_DEF     = 0;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 3;

  // Item functions carried on the input tuser.
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_TICK  = 3'd2;
  localparam logic [2:0] FUNC_INIT  = 3'd3;
  localparam logic [2:0] FUNC_YAW   = 3'd4;

  // Result kinds carried on the output tuser.
  localparam logic [2:0] KIND_OK       = 3'd0;
  localparam logic [2:0] KIND_DATA     = 3'd1;
  localparam logic [2:0] KIND_CRC      = 3'd2;
  localparam logic [2:0] KIND_REJECT   = 3'd3;
  localparam logic [2:0] KIND_INACTIVE = 3'd4;

  // Reflected CRC-8 polynomial.
  localparam logic [7:0] CRC_POLY = 8'h91;

  // Microsecond to millisecond conversion.
  localparam int          TICK_SUM_W = 17;
  localparam int          QUO_W      = 7;
  localparam int          REST_W     = 10;
  localparam logic [16:0] MS_DIVISOR = 17'd1000;

  // Identity and status image loaded at reset.
  localparam logic [7:0] IDENT_B0   = 8'h32;
  localparam logic [7:0] IDENT_B1   = 8'h42;
  localparam logic [7:0] IDENT_B2   = 8'h02;
  localparam logic [7:0] IDENT_B3   = 8'h03;
  localparam logic [7:0] STAT_A0    = 8'd8;
  localparam logic [7:0] STAT_A1    = 8'd9;
  localparam logic [7:0] STAT_A2    = 8'd10;
  localparam logic [7:0] STAT_A3    = 8'd16;
  localparam logic [7:0] STAT_V0    = 8'h04;
  localparam logic [7:0] STAT_V1    = 8'h0E;
  localparam logic [7:0] STAT_V2    = 8'h8D;
  localparam logic [7:0] STAT_V3    = 8'h23;

  typedef struct packed {
    logic       done;
    logic [7:0] crc;
  } crc_res_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
    logic [REST_W-1:0] rem;
  } div_res_t;

  // One bit of the reflected CRC shift.
  function automatic logic [7:0] crc_step(input logic [7:0] crc);
    logic [7:0] t;
    t = crc[0] ? (crc ^ CRC_POLY) : crc;
    return {1'b0, t[7:1]};
  endfunction

  // Content of a register that has not been written since reset. The status
  // bytes are placed after the identity bytes and win where they overlap.
  function automatic logic [7:0] reset_image(input logic [7:0] addr,
                                             input logic [7:0] ident);
    logic [8:0] a9;
    logic [8:0] i9;
    logic [7:0] v;
    a9 = {1'b0, addr};
    i9 = {1'b0, ident};
    if (addr == STAT_A0) begin
      v = STAT_V0;
    end else if (addr == STAT_A1) begin
      v = STAT_V1;
    end else if (addr == STAT_A2) begin
      v = STAT_V2;
    end else if (addr == STAT_A3) begin
      v = STAT_V3;
    end else if (a9 == i9) begin
      v = IDENT_B0;
    end else if (a9 == i9 + 9'd1) begin
      v = IDENT_B1;
    end else if (a9 == i9 + 9'd2) begin
      v = IDENT_B2;
    end else if (a9 == i9 + 9'd3) begin
      v = IDENT_B3;
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/simu_ram.sv =====
module simu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = simu_pkg::REG_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/simu_crc8.sv =====
module simu_crc8 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [7:0]         seed,
  output simu_pkg::crc_res_t res
);
  import simu_pkg::*;

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;

  // Seed is the running CRC already XORed with the data byte; one bit is
  // shifted out per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      crc_nxt  = seed;
    end else if (busy_r) begin
      crc_nxt = crc_step(crc_r);
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    crc_r <= crc_nxt;
  end

  assign res.done = done_r;
  assign res.crc  = crc_r;

endmodule

// ===== rtl/core/simu_tdiv.sv =====
module simu_tdiv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [simu_pkg::TICK_SUM_W-1:0]   dividend,
  output simu_pkg::div_res_t                res
);
  import simu_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [TICK_SUM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [TICK_SUM_W-1:0] trial;

  // Restoring division by 1000, one quotient bit per cycle, most
  // significant first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = MS_DIVISOR << step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(QUO_W - 1);
      rem_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r[REST_W-1:0];

endmodule

// ===== rtl/core/spi_imu_register_slave.sv =====
// Register slave of an inertial sensor as seen from its SPI host, fed one
// item per input transfer: a write-frame byte, a read-frame byte, a time
// tick, a bus-up event or a new yaw value (selected by in_tuser), and
// answering every item with exactly one output transfer carrying a byte and
// a result kind. Items are handled one at a time. A yaw update writes its
// two bytes one after the other through the single RAM write port; a read
// byte that returns a register waits for the registered RAM read and then
// for the bit-serial CRC-8 unit, which shifts one bit per cycle; a tick
// waits for the bit-serial divide by 1000 (seven quotient bits), followed by
// four byte-serial timestamp writes through the single RAM write port. A
// finished result sits in an output register, so the next item is taken
// while the host has still to collect it. The register file is a RAM with
// one valid bit per entry: an entry not written since reset reads as the
// identity and status image, so no clearing pass is needed after reset.
module spi_imu_register_slave #(
  parameter int REG_COUNT      = simu_pkg::REG_COUNT_DEF,
  parameter int TIMESTAMP_ADDR = simu_pkg::TIMESTAMP_ADDR_DEF,
  parameter int YAW_ADDR       = simu_pkg::YAW_ADDR_DEF,
  parameter int IDENT_ADDR     = simu_pkg::IDENT_ADDR_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte, [23:8] tick_us, [24] bus_up, [40:25] yaw_centideg,
  // [47:41] zero
  input  logic [simu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,     // frame_end
  input  logic [simu_pkg::IN_TUSER_W-1:0]  in_tuser,     // [2:0] func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [simu_pkg::OUT_TDATA_W-1:0] out_tdata,    // [7:0] out_byte
  output logic [simu_pkg::OUT_TUSER_W-1:0] out_tuser     // [2:0] result_kind
);
  import simu_pkg::*;

  localparam int         AW        = $clog2(REG_COUNT);
  localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);
  localparam logic [8:0] TS_BASE   = 9'(TIMESTAMP_ADDR);
  localparam logic [8:0] YAW_BASE  = 9'(YAW_ADDR);
  localparam logic [7:0] IDENT_B   = 8'(IDENT_ADDR);

  // One state per phase of an item's work.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_RDWAIT = 8'b0000_0100,
    S_CRC    = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_TS     = 8'b0010_0000,
    S_YAW2   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Latched input item.
  logic [2:0]  func_r, func_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        up_r, up_nxt;
  logic [15:0] yaw_r, yaw_nxt;

  // Device state.
  logic                  bus_active_r, bus_active_nxt;
  logic                  read_pending_r, read_pending_nxt;
  logic [7:0]            read_pointer_r, read_pointer_nxt;
  logic [7:0]            read_remaining_r, read_remaining_nxt;
  logic [7:0]            running_crc_r, running_crc_nxt;
  logic [7:0]            frame_position_r, frame_position_nxt;
  logic [7:0]            frame_head_r, frame_head_nxt;
  logic [7:0]            request_count_r, request_count_nxt;
  logic [REST_W-1:0]     us_rest_r, us_rest_nxt;
  logic [31:0]           ms_count_r, ms_count_nxt;
  logic [REG_COUNT-1:0]  valid_r, valid_nxt;

  // Read bookkeeping across the RAM latency.
  logic [7:0] rd_addr_r, rd_addr_nxt;
  logic       rd_range_r, rd_range_nxt;
  logic       rd_valid_r, rd_valid_nxt;

  // Timestamp byte sequencing.
  logic [1:0] ts_idx_r, ts_idx_nxt;
  logic       ts_carry_r, ts_carry_nxt;

  // Result waiting to enter the output register, and the output register.
  logic [7:0] res_byte_r, res_byte_nxt;
  logic [2:0] res_kind_r, res_kind_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;

  // Register file port.
  logic          wr_req;
  logic [8:0]    wr_addr9;
  logic [7:0]    wr_data;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Serial units.
  logic                  crc_start;
  logic [7:0]            crc_seed;
  crc_res_t              crc_res;
  logic                  div_start;
  logic [TICK_SUM_W-1:0] div_dividend;
  div_res_t              div_res;

  // Working values.
  logic [7:0] head;
  logic [8:0] req_end;
  logic [7:0] rd_value;
  logic [8:0] ts_sum;
  logic [7:0] ts_addend;

  logic in_xfer;

  // No transfer is taken while reset is held.
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign ram_we    = wr_req && (wr_addr9 < REG_LIMIT);

  simu_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr9[AW-1:0]),
    .wdata (wr_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  simu_crc8 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (crc_start),
    .seed  (crc_seed),
    .res   (crc_res)
  );

  simu_tdiv u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .res      (div_res)
  );

  always_comb begin
    state_nxt          = state_r;
    func_nxt           = func_r;
    byte_nxt           = byte_r;
    last_nxt           = last_r;
    tick_nxt           = tick_r;
    up_nxt             = up_r;
    yaw_nxt            = yaw_r;
    bus_active_nxt     = bus_active_r;
    read_pending_nxt   = read_pending_r;
    read_pointer_nxt   = read_pointer_r;
    read_remaining_nxt = read_remaining_r;
    running_crc_nxt    = running_crc_r;
    frame_position_nxt = frame_position_r;
    frame_head_nxt     = frame_head_r;
    request_count_nxt  = request_count_r;
    us_rest_nxt        = us_rest_r;
    ms_count_nxt       = ms_count_r;
    valid_nxt          = valid_r;
    rd_addr_nxt        = rd_addr_r;
    rd_range_nxt       = rd_range_r;
    rd_valid_nxt       = rd_valid_r;
    ts_idx_nxt         = ts_idx_r;
    ts_carry_nxt       = ts_carry_r;
    res_byte_nxt       = res_byte_r;
    res_kind_nxt       = res_kind_r;
    out_byte_nxt       = out_byte_r;
    out_kind_nxt       = out_kind_r;
    // The host taking the result empties the output register.
    out_valid_nxt      = out_valid_r && !out_tready;

    wr_req       = 1'b0;
    wr_addr9     = '0;
    wr_data      = '0;
    ram_raddr    = read_pointer_r[AW-1:0];
    crc_start    = 1'b0;
    crc_seed     = '0;
    div_start    = 1'b0;
    div_dividend = {{(TICK_SUM_W-REST_W){1'b0}}, us_rest_r} + {1'b0, tick_r};
    head         = (frame_position_r == 8'd0) ? byte_r : frame_head_r;
    req_end      = {1'b0, frame_head_r} + {1'b0, request_count_r};
    rd_value     = !rd_range_r ? 8'h00 :
                   rd_valid_r  ? ram_rdata : reset_image(rd_addr_r, IDENT_B);
    ts_addend    = (ts_idx_r == 2'd0) ? {1'b0, div_res.quo} : 8'h00;
    ts_sum       = {1'b0, ms_count_r[7:0]} + {1'b0, ts_addend} + {8'h00, ts_carry_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt  = in_tuser;
          byte_nxt  = in_tdata[7:0];
          last_nxt  = in_tlast;
          tick_nxt  = in_tdata[23:8];
          up_nxt    = in_tdata[24];
          yaw_nxt   = in_tdata[40:25];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_byte_nxt = 8'h00;
        res_kind_nxt = KIND_OK;
        state_nxt    = S_OUT;
        case (func_r)
          FUNC_WRITE: begin
            if (frame_position_r == 8'd0) begin
              frame_head_nxt = byte_r;
            end else if (frame_position_r == 8'd1) begin
              request_count_nxt = byte_r;
            end
            if (!bus_active_r) begin
              res_kind_nxt = KIND_INACTIVE;
            end else if (head[7]) begin
              // Write frame: middle bytes go to consecutive registers, the
              // head and the trailing byte are not stored.
              if (frame_position_r != 8'd0 && !last_r) begin
                wr_req   = 1'b1;
                wr_addr9 = {2'b00, head[6:0]} + {1'b0, frame_position_r} - 9'd1;
                wr_data  = byte_r;
              end
            end else if (frame_position_r == 8'd2 && last_r && !read_pending_r) begin
              // Three-byte read request: address then count.
              if ({1'b0, frame_head_r} < REG_LIMIT && req_end <= REG_LIMIT) begin
                read_pending_nxt   = 1'b1;
                read_pointer_nxt   = frame_head_r;
                read_remaining_nxt = request_count_r;
                running_crc_nxt    = 8'h00;
              end else begin
                res_kind_nxt = KIND_REJECT;
              end
            end
            if (last_r) begin
              frame_position_nxt = 8'd0;
            end else if (frame_position_r != 8'hFF) begin
              frame_position_nxt = frame_position_r + 8'd1;
            end
          end

          FUNC_READ: begin
            res_kind_nxt = KIND_DATA;
            if (!bus_active_r) begin
              res_kind_nxt = KIND_INACTIVE;
            end else if (read_pending_r && read_remaining_r != 8'd0) begin
              // Register data: the RAM read is issued now, the CRC follows.
              rd_addr_nxt        = read_pointer_r;
              rd_range_nxt       = {1'b0, read_pointer_r} < REG_LIMIT;
              rd_valid_nxt       = valid_r[read_pointer_r[AW-1:0]];
              read_pointer_nxt   = read_pointer_r + 8'd1;
              read_remaining_nxt = read_remaining_r - 8'd1;
              state_nxt          = S_RDWAIT;
            end else if (read_pending_r) begin
              res_byte_nxt     = running_crc_r;
              res_kind_nxt     = KIND_CRC;
              read_pending_nxt = 1'b0;
            end
            if (last_r) begin
              read_pending_nxt = 1'b0;
            end
          end

          FUNC_TICK: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end

          FUNC_INIT: begin
            if (up_r) begin
              bus_active_nxt = 1'b1;
            end
          end

          FUNC_YAW: begin
            wr_req    = 1'b1;
            wr_addr9  = YAW_BASE;
            wr_data   = yaw_r[7:0];
            state_nxt = S_YAW2;
          end

          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        res_byte_nxt = rd_value;
        crc_start    = 1'b1;
        crc_seed     = running_crc_r ^ rd_value;
        state_nxt    = S_CRC;
      end

      S_CRC: begin
        if (crc_res.done) begin
          running_crc_nxt = crc_res.crc;
          state_nxt       = S_OUT;
        end
      end

      S_DIV: begin
        if (div_res.done) begin
          us_rest_nxt  = div_res.rem;
          ts_idx_nxt   = 2'd0;
          ts_carry_nxt = 1'b0;
          state_nxt    = S_TS;
        end
      end

      S_TS: begin
        // Add the whole milliseconds a byte at a time, lowest byte first,
        // rotating the count and mirroring each byte into the file.
        ms_count_nxt = {ts_sum[7:0], ms_count_r[31:8]};
        ts_carry_nxt = ts_sum[8];
        ts_idx_nxt   = ts_idx_r + 2'd1;
        wr_req       = 1'b1;
        wr_addr9     = TS_BASE + {7'd0, ts_idx_r};
        wr_data      = ts_sum[7:0];
        if (ts_idx_r == 2'd3) begin
          state_nxt = S_OUT;
        end
      end

      S_YAW2: begin
        wr_req    = 1'b1;
        wr_addr9  = YAW_BASE + 9'd1;
        wr_data   = yaw_r[15:8];
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_kind_nxt  = res_kind_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ram_we) begin
      valid_nxt[wr_addr9[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      bus_active_r     <= 1'b0;
      read_pending_r   <= 1'b0;
      read_pointer_r   <= '0;
      read_remaining_r <= '0;
      running_crc_r    <= '0;
      frame_position_r <= '0;
      frame_head_r     <= '0;
      request_count_r  <= '0;
      us_rest_r        <= '0;
      ms_count_r       <= '0;
      valid_r          <= '0;
      ts_idx_r         <= '0;
      ts_carry_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      bus_active_r     <= bus_active_nxt;
      read_pending_r   <= read_pending_nxt;
      read_pointer_r   <= read_pointer_nxt;
      read_remaining_r <= read_remaining_nxt;
      running_crc_r    <= running_crc_nxt;
      frame_position_r <= frame_position_nxt;
      frame_head_r     <= frame_head_nxt;
      request_count_r  <= request_count_nxt;
      us_rest_r        <= us_rest_nxt;
      ms_count_r       <= ms_count_nxt;
      valid_r          <= valid_nxt;
      ts_idx_r         <= ts_idx_nxt;
      ts_carry_r       <= ts_carry_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    tick_r     <= tick_nxt;
    up_r       <= up_nxt;
    yaw_r      <= yaw_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_range_r <= rd_range_nxt;
    rd_valid_r <= rd_valid_nxt;
    res_byte_r <= res_byte_nxt;
    res_kind_r <= res_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;

  // A pending read can only have been set up while the bus was active, and
  // the bus is never taken down again.
  a_pending_needs_bus: assert property (@(posedge clk) disable iff (!rst_n)
    read_pending_r |-> bus_active_r)
    else $error("read pending while the bus is inactive");

  // The range check keeps every remaining read inside the register file.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    read_pending_r |-> ({1'b0, read_pointer_r} + {1'b0, read_remaining_r} <= REG_LIMIT))
    else $error("pending read runs past the register file");

  // The serial units finish only while the controller waits for them.
  a_crc_done_in_crc: assert property (@(posedge clk) disable iff (!rst_n)
    crc_res.done |-> (state_r == S_CRC))
    else $error("CRC unit finished outside its wait state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

endmodule
